// ===== rtl/mlkc_pkg.sv =====
// Package for the multi-length k-mer counter: sizes, codes, payload and
// command/status types, and the bank start table. No dependencies.
package mlkc_pkg;

   localparam int MAX_K = 8;
   localparam int COUNT_BITS = 32;
   localparam int K_BITS = 4;
   localparam int HIST_BITS = 2 * MAX_K;
   localparam longint TABLE_SIZE = ((64'd1 << (2 * MAX_K + 2)) - 64'd4) / 3;
   localparam int ADDR_BITS = $clog2(TABLE_SIZE);
   localparam int BANK_ENTRIES = 2 ** K_BITS;
   localparam int PADDR_BITS = 3;

   localparam logic [K_BITS-1:0] SHORTEST_K_RESET = K_BITS'(1);
   localparam logic [K_BITS-1:0] LONGEST_K_RESET = K_BITS'(8);
   localparam logic [K_BITS-1:0] MAX_K_CODE = K_BITS'(MAX_K);

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic REG_SHORTEST_K = 1'b0;
   localparam logic REG_LONGEST_K = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_ZERO  = 2'd0,
      RSP_RANGE = 2'd1,
      RSP_COUNT = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [1:0]        nucleotide;
      logic [K_BITS-1:0] read_length;
      logic [15:0]       kmer_index;
   } req_type;

   typedef struct packed {
      logic [31:0] count;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic         push_start;
      logic         read_start;
      logic         clear_start;
      logic         mem_rd_push;
      logic         mem_rd_read;
      logic         mem_wr_push;
      logic         sweep_wr;
      logic         rsp_fire;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic iter_done;
      logic read_bad;
      logic sweep_last;
   } stat_type;

   typedef logic [BANK_ENTRIES-1:0][ADDR_BITS-1:0] bank_table_type;

   function automatic bank_table_type build_bank_table();
      bank_table_type tbl;
      longint acc;
      acc = 0;
      for (int k = 0; k < BANK_ENTRIES; k++) begin
         tbl[k] = '0;
         if (k >= 1 && k <= MAX_K) begin
            tbl[k] = ADDR_BITS'(acc);
            acc = acc + (64'd1 << (2 * k));
         end
      end
      return tbl;
   endfunction

   localparam bank_table_type BANK_BASE = build_bank_table();

endpackage

// ===== rtl/multi_length_kmer_counter.sv =====
// Top level of the multi-length k-mer counter: configuration registers and
// the controller and datapath. Depends on mlkc_pkg, mlkc_ctrl, mlkc_datapath.
//
// A transaction is taken when start is high and busy is low; its result shows
// on rsp_data for one cycle with rsp_valid, and the receiver cannot stall it.
// Every operation gives one result. Counters sit in a single memory with one
// read and one write port, so a push does one read-modify-write per counted
// length, with the result strobe in the first cycle where busy is low again.
// A read checks its length and index and then reads the memory, skipping the
// memory read and giving a range status when either is out of range; an
// unused operation code gives a zero result while busy stays low. After
// reset, and after each clear, a sweep zeroes all 87380 counters one per
// cycle, keeping busy high throughout; the clear result is given in the
// first cycle of that sweep. Register writes are taken at all times.
module multi_length_kmer_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mlkc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output mlkc_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mlkc_pkg::PADDR_BITS-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import mlkc_pkg::*;

   logic [K_BITS-1:0] shortest_k_ff, shortest_k_in;
   logic [K_BITS-1:0] longest_k_ff, longest_k_in;
   logic              csr_write;
   cmd_type           cmd;
   stat_type          stat;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      shortest_k_in = shortest_k_ff;
      longest_k_in = longest_k_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_SHORTEST_K: shortest_k_in = pwdata[K_BITS-1:0];
            REG_LONGEST_K: longest_k_in = pwdata[K_BITS-1:0];
            default: shortest_k_in = shortest_k_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SHORTEST_K: prdata = 32'(shortest_k_ff);
         REG_LONGEST_K: prdata = 32'(longest_k_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shortest_k_ff <= SHORTEST_K_RESET;
         longest_k_ff <= LONGEST_K_RESET;
      end else begin
         shortest_k_ff <= shortest_k_in;
         longest_k_ff <= longest_k_in;
      end
   end

   mlkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   mlkc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .shortest_k (shortest_k_ff),
      .longest_k  (longest_k_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/mlkc_ctrl.sv =====
// Controller state machine of the k-mer counter: sequences clearing sweeps,
// per-length count updates and reads. Depends on mlkc_pkg.
module mlkc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         operation,
   input  mlkc_pkg::stat_type stat,
   output mlkc_pkg::cmd_type  cmd,
   output logic               busy
);
   import mlkc_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_PCHK  = 6'b000100,
      S_PWR   = 6'b001000,
      S_RRD   = 6'b010000,
      S_RDATA = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_kind = RSP_ZERO;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               case (operation)
                  OP_PUSH: begin
                     cmd.push_start = 1'b1;
                     state_in = S_PCHK;
                  end
                  OP_READ: begin
                     cmd.read_start = 1'b1;
                     state_in = S_RRD;
                  end
                  OP_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     cmd.rsp_fire = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     cmd.rsp_fire = 1'b1;
                  end
               endcase
            end
         end
         S_PCHK: begin
            if (stat.iter_done) begin
               cmd.rsp_fire = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.mem_rd_push = 1'b1;
               state_in = S_PWR;
            end
         end
         S_PWR: begin
            cmd.mem_wr_push = 1'b1;
            state_in = S_PCHK;
         end
         S_RRD: begin
            if (stat.read_bad) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_kind = RSP_RANGE;
               state_in = S_IDLE;
            end else begin
               cmd.mem_rd_read = 1'b1;
               state_in = S_RDATA;
            end
         end
         S_RDATA: begin
            cmd.rsp_fire = 1'b1;
            cmd.rsp_kind = RSP_COUNT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mlkc_datapath.sv =====
// Datapath of the k-mer counter: base history, length iterator, counter
// memory with clearing sweep, and the result register. Depends on mlkc_pkg.
module mlkc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mlkc_pkg::req_type             req_data,
   input  logic [mlkc_pkg::K_BITS-1:0]   shortest_k,
   input  logic [mlkc_pkg::K_BITS-1:0]   longest_k,
   input  mlkc_pkg::cmd_type             cmd,
   output mlkc_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output mlkc_pkg::rsp_type             rsp_data
);
   import mlkc_pkg::*;

   logic [COUNT_BITS-1:0] count_mem [TABLE_SIZE];

   logic [HIST_BITS-1:0]  hist_ff, hist_in;
   logic [K_BITS-1:0]     seen_ff, seen_in;
   logic [K_BITS-1:0]     k_ff, k_in;
   logic [K_BITS-1:0]     hi_ff, hi_in;
   logic                  lo_zero_ff, lo_zero_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [ADDR_BITS-1:0]  read_addr_ff, read_addr_in;
   logic                  read_bad_ff, read_bad_in;
   logic [ADDR_BITS-1:0]  sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [HIST_BITS-1:0]  push_code;
   logic [ADDR_BITS-1:0]  push_addr;
   logic [K_BITS-1:0]     seen_next;
   logic [K_BITS-1:0]     hi_cap;
   logic                  idx_over;
   logic [ADDR_BITS-1:0]  mem_ra;
   logic [ADDR_BITS-1:0]  mem_wa;
   logic [COUNT_BITS-1:0] mem_wd;
   logic                  mem_we;
   logic                  mem_re;
   logic [COUNT_BITS-1:0] count_inc;

   always_comb begin
      for (int i = 0; i < HIST_BITS; i++) begin
         push_code[i] = hist_ff[i] && ((K_BITS + 1)'(i) < {k_ff, 1'b0});
      end
      idx_over = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (req_data.kmer_index[i] && ((K_BITS + 2)'(i) >= {1'b0, req_data.read_length, 1'b0}))
         begin
            idx_over = 1'b1;
         end
      end
   end

   assign push_addr = BANK_BASE[k_ff] + ADDR_BITS'(push_code);
   assign seen_next = (seen_ff == MAX_K_CODE) ? seen_ff : seen_ff + K_BITS'(1);
   assign count_inc = (rdata_ff == '1) ? rdata_ff : rdata_ff + COUNT_BITS'(1);

   always_comb begin
      hi_cap = (longest_k > MAX_K_CODE) ? MAX_K_CODE : longest_k;
      if (hi_cap > seen_next) begin
         hi_cap = seen_next;
      end
   end

   always_comb begin
      hist_in = hist_ff;
      seen_in = seen_ff;
      k_in = k_ff;
      hi_in = hi_ff;
      lo_zero_in = lo_zero_ff;
      addr_in = addr_ff;
      read_addr_in = read_addr_ff;
      read_bad_in = read_bad_ff;
      sweep_in = sweep_ff;
      if (cmd.push_start) begin
         hist_in = {hist_ff[HIST_BITS-3:0], req_data.nucleotide};
         seen_in = seen_next;
         k_in = shortest_k;
         hi_in = hi_cap;
         lo_zero_in = (shortest_k == '0);
      end
      if (cmd.read_start) begin
         read_addr_in = BANK_BASE[req_data.read_length] + ADDR_BITS'(req_data.kmer_index);
         read_bad_in = (req_data.read_length == '0) || (req_data.read_length > MAX_K_CODE)
            || idx_over;
      end
      if (cmd.clear_start) begin
         hist_in = '0;
         seen_in = '0;
         sweep_in = '0;
      end
      if (cmd.mem_rd_push) begin
         addr_in = push_addr;
      end
      if (cmd.mem_wr_push) begin
         k_in = k_ff + K_BITS'(1);
      end
      if (cmd.sweep_wr) begin
         sweep_in = sweep_ff + ADDR_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_fire;
      rsp_in = rsp_ff;
      if (cmd.rsp_fire) begin
         rsp_in.count = '0;
         rsp_in.status = STATUS_OK;
         case (cmd.rsp_kind)
            RSP_RANGE: rsp_in.status = STATUS_RANGE;
            RSP_COUNT: rsp_in.count = 32'(rdata_ff);
            default: rsp_in.count = '0;
         endcase
      end
   end

   assign mem_re = cmd.mem_rd_push || cmd.mem_rd_read;
   assign mem_ra = cmd.mem_rd_read ? read_addr_ff : push_addr;
   assign mem_we = cmd.mem_wr_push || cmd.sweep_wr;
   assign mem_wa = cmd.sweep_wr ? sweep_ff : addr_ff;
   assign mem_wd = cmd.sweep_wr ? '0 : count_inc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= count_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         seen_ff <= '0;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff <= hist_in;
         seen_ff <= seen_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      hi_ff <= hi_in;
      lo_zero_ff <= lo_zero_in;
      addr_ff <= addr_in;
      read_addr_ff <= read_addr_in;
      read_bad_ff <= read_bad_in;
      rsp_ff <= rsp_in;
   end

   assign stat.iter_done = lo_zero_ff || (k_ff > hi_ff);
   assign stat.read_bad = read_bad_ff;
   assign stat.sweep_last = (sweep_ff == ADDR_BITS'(TABLE_SIZE - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/mlkc_checker.sv =====
// Port-level checker for the k-mer counter, bound to the top level.
// Depends on mlkc_pkg and multi_length_kmer_counter.
module mlkc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input mlkc_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input mlkc_pkg::rsp_type               rsp_data
);
   import mlkc_pkg::*;

   logic accepted;
   assign accepted = start && !busy;

   a_reset_sweeps: assert property (@(posedge clock) reset |=> busy)
      else $error("Counters are not swept after reset.");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      accepted && (req_data.operation == OP_CLEAR) |=> busy && rsp_valid)
      else $error("Clear transaction did not start a sweep with a result.");

   a_unused_fast: assert property (@(posedge clock) disable iff (reset)
      accepted && (req_data.operation == OP_UNUSED) |=> rsp_valid && !busy
         && (rsp_data.count == '0) && (rsp_data.status == STATUS_OK))
      else $error("Unused operation code gave a wrong result.");

   a_push_no_early: assert property (@(posedge clock) disable iff (reset)
      accepted && (req_data.operation == OP_PUSH) |=> !rsp_valid && busy)
      else $error("Push transaction produced a result too early.");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_RANGE) |-> rsp_data.count == '0)
      else $error("Out of range result carries a nonzero count.");

endmodule

bind multi_length_kmer_counter mlkc_checker u_mlkc_checker (.*);
